// ===== hdl/rru_pkg.sv =====
// Package: types and constants shared by the register rename unit
package rru_pkg;
  localparam int LOG_REGS = 32;
  localparam int PHYS_REGS = 128;
  localparam int FIFO_DEPTH = PHYS_REGS - LOG_REGS;
  localparam int LW = 5;
  localparam int PW = 7;
  localparam int FW = 7;
  localparam int VW = 32;

  localparam logic [2:0] ACT_RENAME = 3'd0;
  localparam logic [2:0] ACT_WB = 3'd1;
  localparam logic [2:0] ACT_COMMIT = 3'd2;
  localparam logic [2:0] ACT_FLUSH = 3'd3;
  localparam logic [2:0] ACT_READ = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [LW-1:0] src1_logical;
    logic [LW-1:0] src2_logical;
    logic [LW-1:0] dest_logical;
    logic [PW-1:0] phys_reg;
    logic [VW-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic ok;
    logic [PW-1:0] src1_phys;
    logic src1_rdy;
    logic [VW-1:0] src1_val;
    logic [PW-1:0] src2_phys;
    logic src2_rdy;
    logic [VW-1:0] src2_val;
    logic [PW-1:0] dest_phys;
    logic [FW-1:0] free_count;
    logic [31:0] renames_done;
    logic [31:0] stalls_seen;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch input item
    logic rd_a;      // issue first read phase
    logic exec;      // perform action
    logic scan;      // one flush/commit scan step
    logic scan_clr;  // start scan
    logic finish;    // build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] action;
    logic scan_done;
  } dp_sts_t;
endpackage

// ===== hdl/rru_ctrl.sv =====
// Controller: sequences each item through lookup, execute, scan (commit and flush only) and result
module rru_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  rru_pkg::dp_sts_t sts,
  output rru_pkg::dp_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_EX = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_a = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.exec = 1'b1;
        if (sts.action inside {rru_pkg::ACT_FLUSH, rru_pkg::ACT_COMMIT}) begin
          cmd.scan_clr = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait here until the result register is free or being taken
        if (!ov_r || !out_stall) begin
          cmd.finish = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

// ===== hdl/rru_dp.sv =====
// Datapath: maps, register file, free FIFO and counters
module rru_dp (
  input  logic clk,
  input  logic rst_n,
  input  rru_pkg::in_item_t in_item,
  input  rru_pkg::dp_cmd_t cmd,
  output rru_pkg::dp_sts_t sts,
  output rru_pkg::out_item_t out_item
);
  localparam int LW = rru_pkg::LW;
  localparam int PW = rru_pkg::PW;
  localparam int VW = rru_pkg::VW;
  localparam int FW = rru_pkg::FW;

  rru_pkg::in_item_t it_r;
  rru_pkg::out_item_t res_r, res_nxt;

  // maps (small, flip-flops)
  logic [PW-1:0] smap_r [rru_pkg::LOG_REGS];
  logic [PW-1:0] cmap_r [rru_pkg::LOG_REGS];
  logic [rru_pkg::PHYS_REGS-1:0] held_r;
  logic [rru_pkg::PHYS_REGS-1:0] rdy_r;
  logic [rru_pkg::PHYS_REGS-1:0] vvalid_r;  // value written and not cleared since
  logic [VW-1:0] vmem [rru_pkg::PHYS_REGS];
  logic [PW-1:0] fifo_mem [rru_pkg::FIFO_DEPTH];
  logic [FW-1:0] head_r, tail_r, cnt_r;
  // until the tail first wraps or a flush, entries at or past tail_r are still in reset
  // order: entry i = LOG_REGS + i
  logic fifo_init_r;
  logic [31:0] ren_r, stl_r;

  logic [PW-1:0] p1_r, p2_r, p1, p2, a1, hd_r;
  logic [VW-1:0] v1_raw_r, v2_raw_r, v1, v2;
  logic r1_r, r2_r, vv1_r, vv2_r;
  logic stall_r;
  logic [PW-1:0] old_r;
  logic [PW-1:0] scan_r;
  logic hold_acc_r;
  logic has_dest, map_hit, release_c, push_c;
  logic [PW-1:0] push_val;

  assign has_dest = it_r.dest_logical != '0;
  assign p1 = smap_r[it_r.src1_logical];
  assign p2 = smap_r[it_r.src2_logical];
  // port 1 reads the source on rename and phys_reg on read
  assign a1 = (it_r.action == rru_pkg::ACT_READ) ? it_r.phys_reg : p1;

  assign sts.action = it_r.action;
  assign sts.scan_done = (it_r.action == rru_pkg::ACT_FLUSH)
    ? (scan_r == PW'(rru_pkg::PHYS_REGS - 1))
    : (scan_r == PW'(rru_pkg::LOG_REGS - 1));

  assign map_hit = cmap_r[scan_r[LW-1:0]] == old_r;
  assign release_c = cmd.scan && it_r.action == rru_pkg::ACT_COMMIT && has_dest
                     && sts.scan_done && old_r >= PW'(rru_pkg::LOG_REGS);

  always_comb begin
    push_c = 1'b0;
    push_val = scan_r;
    if (cmd.scan && it_r.action == rru_pkg::ACT_FLUSH) begin
      push_c = !held_r[scan_r];
    end else if (release_c) begin
      // a full FIFO drops the released register
      push_c = cnt_r != FW'(rru_pkg::FIFO_DEPTH);
      push_val = old_r;
    end
  end

  // lookup: everything an item reads is captured before it executes
  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_item;
    if (cmd.rd_a) begin
      p1_r <= p1;
      p2_r <= p2;
      r1_r <= rdy_r[a1];
      r2_r <= rdy_r[p2];
      vv1_r <= vvalid_r[a1];
      vv2_r <= vvalid_r[p2];
      old_r <= cmap_r[it_r.dest_logical];
      stall_r <= has_dest && cnt_r == '0;
      hd_r <= (fifo_init_r && head_r >= tail_r)
              ? PW'(32'(rru_pkg::LOG_REGS) + 32'(head_r))
              : fifo_mem[head_r];
    end
  end

  // value file: registered reads at lookup, write on writeback
  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      v1_raw_r <= vmem[a1];
      v2_raw_r <= vmem[p2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && it_r.action == rru_pkg::ACT_WB && it_r.phys_reg != '0)
      vmem[it_r.phys_reg] <= it_r.write_value;
  end

  always_ff @(posedge clk) begin
    if (push_c) fifo_mem[tail_r] <= push_val;
  end

  assign v1 = vv1_r ? v1_raw_r : '0;
  assign v2 = vv2_r ? v2_raw_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rru_pkg::LOG_REGS; i++) begin
        smap_r[i] <= PW'(i);
        cmap_r[i] <= PW'(i);
      end
      for (int i = 0; i < rru_pkg::PHYS_REGS; i++) held_r[i] <= (i < rru_pkg::LOG_REGS);
      rdy_r <= '1;
      vvalid_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r <= FW'(rru_pkg::FIFO_DEPTH);
      fifo_init_r <= 1'b1;
      ren_r <= '0;
      stl_r <= '0;
      scan_r <= '0;
      hold_acc_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (it_r.action)
          rru_pkg::ACT_RENAME: begin
            if (stall_r) stl_r <= stl_r + 32'd1;
            else begin
              ren_r <= ren_r + 32'd1;
              if (has_dest) begin
                smap_r[it_r.dest_logical] <= hd_r;
                rdy_r[hd_r] <= 1'b0;
                head_r <= (head_r == FW'(rru_pkg::FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
                cnt_r <= cnt_r - 1'b1;
              end
            end
          end
          rru_pkg::ACT_WB: begin
            if (it_r.phys_reg != '0) begin
              rdy_r[it_r.phys_reg] <= 1'b1;
              vvalid_r[it_r.phys_reg] <= 1'b1;
            end
          end
          rru_pkg::ACT_COMMIT: begin
            if (has_dest) begin
              cmap_r[it_r.dest_logical] <= it_r.phys_reg;
              held_r[it_r.phys_reg] <= 1'b1;
            end
          end
          rru_pkg::ACT_FLUSH: begin
            for (int i = 0; i < rru_pkg::LOG_REGS; i++) smap_r[i] <= cmap_r[i];
            head_r <= '0;
            tail_r <= '0;
            cnt_r <= '0;
            fifo_init_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.scan_clr) begin
        scan_r <= (it_r.action == rru_pkg::ACT_FLUSH) ? PW'(rru_pkg::LOG_REGS) : '0;
        hold_acc_r <= 1'b0;
      end
      if (cmd.scan) begin
        scan_r <= scan_r + 1'b1;
        if (it_r.action == rru_pkg::ACT_COMMIT && has_dest) begin
          // recompute held bit of the replaced register over the new map
          if (map_hit) hold_acc_r <= 1'b1;
          if (sts.scan_done) held_r[old_r] <= hold_acc_r || map_hit;
        end
        if (release_c) begin
          rdy_r[old_r] <= 1'b1;
          vvalid_r[old_r] <= 1'b0;
        end
        if (push_c) begin
          tail_r <= (tail_r == FW'(rru_pkg::FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          cnt_r <= cnt_r + 1'b1;
          if (tail_r == FW'(rru_pkg::FIFO_DEPTH - 1)) fifo_init_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.ok = 1'b1;
    case (it_r.action)
      rru_pkg::ACT_RENAME: begin
        if (stall_r) res_nxt.ok = 1'b0;
        else begin
          res_nxt.src1_phys = p1_r;
          res_nxt.src1_rdy = r1_r;
          res_nxt.src1_val = v1;
          res_nxt.src2_phys = p2_r;
          res_nxt.src2_rdy = r2_r;
          res_nxt.src2_val = v2;
          res_nxt.dest_phys = has_dest ? hd_r : '0;
        end
      end
      rru_pkg::ACT_READ: begin
        res_nxt.src1_rdy = r1_r;
        res_nxt.src1_val = v1;
      end
      default: ;
    endcase
    res_nxt.free_count = cnt_r;
    res_nxt.renames_done = ren_r;
    res_nxt.stalls_seen = stl_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) res_r <= res_nxt;
  end

  assign out_item = res_r;
endmodule

// ===== hdl/register_rename_unit.sv =====
// Top level: register rename unit
// One item is processed at a time: after the accepting edge the item passes
// through the lookup, execute and result states, and the next item is
// accepted only once the result has been written. Commit adds a scan of the
// committed map and flush a walk of the register numbers that refills the
// free FIFO. The result register holds until taken; the next item is
// accepted and processed meanwhile and its result waits until the register
// frees.
module register_rename_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  rru_pkg::in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output rru_pkg::out_item_t out_item
);
  rru_pkg::dp_cmd_t cmd;
  rru_pkg::dp_sts_t sts;

  rru_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd);
  rru_dp u_dp (.clk, .rst_n, .in_item, .cmd, .sts, .out_item);

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.free_count <= 7'd96) else $error("free count overflow");
  a_stall_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.ok |-> out_item.dest_phys == '0)
    else $error("stalled rename allocated");
`endif
endmodule

// ===== tb/rru_checker.sv =====
// Checker: watches both channels of the rename unit, predicts results and compares them
`timescale 1ns / 100ps
module rru_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rru_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rru_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);
  localparam int PW = rru_pkg::PW;
  localparam int VW = rru_pkg::VW;
  localparam int FW = rru_pkg::FW;

  logic [PW-1:0] spec_map [rru_pkg::LOG_REGS];
  logic [PW-1:0] cmt_map [rru_pkg::LOG_REGS];
  logic          cmt_held [rru_pkg::PHYS_REGS];
  logic [VW-1:0] pvalue [rru_pkg::PHYS_REGS];
  logic          pready [rru_pkg::PHYS_REGS];
  logic [PW-1:0] free_q [$];
  logic [31:0]   rename_cnt;
  logic [31:0]   stall_cnt;
  rru_pkg::out_item_t expected_q [$];

  function automatic void refill_free();
    free_q.delete();
    for (int r = rru_pkg::LOG_REGS; r < rru_pkg::PHYS_REGS; r++)
      if (!cmt_held[r]) free_q.push_back(PW'(r));
  endfunction

  function automatic void reset_state();
    for (int i = 0; i < rru_pkg::LOG_REGS; i++) begin
      spec_map[i] = PW'(i);
      cmt_map[i] = PW'(i);
    end
    for (int i = 0; i < rru_pkg::PHYS_REGS; i++) begin
      cmt_held[i] = (i < rru_pkg::LOG_REGS);
      pvalue[i] = '0;
      pready[i] = 1'b1;
    end
    refill_free();
    rename_cnt = '0;
    stall_cnt = '0;
  endfunction

  function automatic rru_pkg::out_item_t rename_step(rru_pkg::in_item_t it);
    rru_pkg::out_item_t r;
    logic [PW-1:0] old_p;
    logic [PW-1:0] d;
    logic held;
    r = '0;
    r.ok = 1'b1;
    case (it.action)
      rru_pkg::ACT_RENAME: begin
        if (it.dest_logical != 0 && free_q.size() == 0) begin
          stall_cnt++;
          r.ok = 1'b0;
        end else begin
          r.src1_phys = spec_map[it.src1_logical];
          r.src1_rdy = pready[r.src1_phys];
          r.src1_val = pvalue[r.src1_phys];
          r.src2_phys = spec_map[it.src2_logical];
          r.src2_rdy = pready[r.src2_phys];
          r.src2_val = pvalue[r.src2_phys];
          if (it.dest_logical != 0) begin
            d = free_q.pop_front();
            spec_map[it.dest_logical] = d;
            pready[d] = 1'b0;
            r.dest_phys = d;
          end
          rename_cnt++;
        end
      end
      rru_pkg::ACT_WB: begin
        if (it.phys_reg != 0) begin
          pvalue[it.phys_reg] = it.write_value;
          pready[it.phys_reg] = 1'b1;
        end
      end
      rru_pkg::ACT_COMMIT: begin
        if (it.dest_logical != 0) begin
          old_p = cmt_map[it.dest_logical];
          cmt_map[it.dest_logical] = it.phys_reg;
          held = 1'b0;
          for (int i = 0; i < rru_pkg::LOG_REGS; i++)
            if (cmt_map[i] == old_p) held = 1'b1;
          cmt_held[old_p] = held;
          cmt_held[it.phys_reg] = 1'b1;
          if (old_p >= rru_pkg::LOG_REGS) begin
            pready[old_p] = 1'b1;
            pvalue[old_p] = '0;
            // a full free list drops the released register
            if (free_q.size() < rru_pkg::FIFO_DEPTH) free_q.push_back(old_p);
          end
        end
      end
      rru_pkg::ACT_FLUSH: begin
        for (int i = 0; i < rru_pkg::LOG_REGS; i++) spec_map[i] = cmt_map[i];
        refill_free();
      end
      rru_pkg::ACT_READ: begin
        r.src1_rdy = pready[it.phys_reg];
        r.src1_val = pvalue[it.phys_reg];
      end
      default: ;
    endcase
    r.free_count = FW'(free_q.size());
    r.renames_done = rename_cnt;
    r.stalls_seen = stall_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    rru_pkg::out_item_t want;
    if (!rst_n) begin
      reset_state();
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result item %p", out_item);
        end else begin
          want = expected_q.pop_front();
          if (want !== out_item) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch:\n  expected %p\n  actual   %p", want, out_item);
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(rename_step(in_item));
      pending <= expected_q.size();
    end
  end
endmodule

// ===== tb/tb_register_rename_unit.sv =====
// Testbench top: stimulus, flow control and verdict for the register rename unit
`timescale 1ns / 100ps
module tb_register_rename_unit;
  localparam int PW = rru_pkg::PW;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  rru_pkg::in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  rru_pkg::out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycle_cnt;
  bit        calm;
  bit        hold_long;
  int        n_items;
  int        n_flush;

  register_rename_unit u_top (.*);

  rru_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2000000) begin
      $display("timeout at cycle %0d", cycle_cnt);
      $display("register_rename_unit regression: fail");
      $finish;
    end
  end

  // result side: random stall bursts, a long hold-off once, none at the end
  initial begin
    int burst;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(3) == 0) begin
        burst = $urandom_range(11, 1);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send(rru_pkg::in_item_t it);
    int gap;
    if (!calm && $urandom_range(4) == 0) begin
      gap = $urandom_range(11, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (it.action == rru_pkg::ACT_FLUSH) n_flush++;
  endtask

  function automatic rru_pkg::in_item_t make_item(logic [2:0] act);
    rru_pkg::in_item_t it;
    it.action = act;
    it.src1_logical = 5'($urandom);
    it.src2_logical = 5'($urandom);
    it.dest_logical = 5'($urandom);
    it.phys_reg = 7'($urandom);
    it.write_value = 32'($urandom);
    return it;
  endfunction

  initial begin
    rru_pkg::in_item_t it;
    logic [PW-1:0] inflight [$];
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cycle_cnt = 0;
    calm = 1'b0;
    hold_long = 1'b0;
    n_items = 0;
    n_flush = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and each action, including unused codes
    send('{rru_pkg::ACT_READ, 5'd0, 5'd0, 5'd0, 7'd0, 32'd0});
    send('{rru_pkg::ACT_READ, 5'd0, 5'd0, 5'd0, 7'd127, 32'd0});
    send('{rru_pkg::ACT_WB, 5'd0, 5'd0, 5'd0, 7'd0, 32'hFFFF_FFFF});
    send('{rru_pkg::ACT_WB, 5'd0, 5'd0, 5'd0, 7'd127, 32'hFFFF_FFFF});
    send('{rru_pkg::ACT_RENAME, 5'd31, 5'd0, 5'd0, 7'd0, 32'd0});
    send('{rru_pkg::ACT_RENAME, 5'd1, 5'd31, 5'd31, 7'd127, 32'hFFFF_FFFF});
    send('{rru_pkg::ACT_READ, 5'd0, 5'd0, 5'd0, 7'd127, 32'd0});
    send('{rru_pkg::ACT_COMMIT, 5'd0, 5'd0, 5'd0, 7'd40, 32'd0});
    send('{rru_pkg::ACT_COMMIT, 5'd0, 5'd0, 5'd31, 7'd32, 32'd0});
    send('{rru_pkg::ACT_COMMIT, 5'd0, 5'd0, 5'd31, 7'd5, 32'd0});
    send('{rru_pkg::ACT_COMMIT, 5'd0, 5'd0, 5'd5, 7'd31, 32'd0});
    send('{rru_pkg::ACT_FLUSH, 5'd0, 5'd0, 5'd0, 7'd0, 32'd0});
    send('{3'd5, 5'd31, 5'd31, 5'd31, 7'd127, 32'hFFFF_FFFF});
    send('{3'd7, 5'd0, 5'd0, 5'd0, 7'd0, 32'd0});
    // drain the free list to force rename stalls, with a long receiver hold-off
    hold_long = 1'b1;
    for (int i = 0; i < 100; i++)
      send('{rru_pkg::ACT_RENAME, 5'(i), 5'(i + 7), 5'(1 + i % 31), 7'd0, 32'd0});
    send('{rru_pkg::ACT_RENAME, 5'd2, 5'd3, 5'd0, 7'd0, 32'd0});
    send('{rru_pkg::ACT_FLUSH, 5'd0, 5'd0, 5'd0, 7'd0, 32'd0});

    // random: mostly rename/writeback/commit flows on stand-in register numbers
    for (int i = 0; i < 2000; i++) begin
      if (i == 1700) calm = 1'b1;
      pick = $urandom_range(99);
      if (pick < 40) begin
        it = make_item(rru_pkg::ACT_RENAME);
        if ($urandom_range(9) == 0) it.dest_logical = '0;
      end else if (pick < 60) begin
        it = make_item(rru_pkg::ACT_WB);
        if (inflight.size() > 0 && $urandom_range(3) != 0)
          it.phys_reg = inflight[$urandom_range(inflight.size() - 1)];
      end else if (pick < 80) begin
        it = make_item(rru_pkg::ACT_COMMIT);
        if (inflight.size() > 0 && $urandom_range(3) != 0)
          it.phys_reg = inflight.pop_front();
      end else if (pick < 93) begin
        it = make_item(rru_pkg::ACT_READ);
      end else if (pick < 97) begin
        it = make_item(rru_pkg::ACT_FLUSH);
        inflight.delete();
      end else begin
        it = make_item(3'($urandom_range(7, 5)));
      end
      send(it);
      // stand-in for allocated registers: random picks from the renamable range
      if (it.action == rru_pkg::ACT_RENAME && it.dest_logical != 0)
        inflight.push_back(PW'($urandom_range(rru_pkg::PHYS_REGS - 1, rru_pkg::LOG_REGS)));
      if (inflight.size() > 64) void'(inflight.pop_front());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d items incl. %0d flushes: renames, stalls, writebacks,", n_items,
             n_flush);
    $display("commits with releases, reads and unused codes under random flow control");
    if (fail_count == 0 && pending == 0)
      $display("register_rename_unit regression: pass");
    else
      $display("register_rename_unit regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/rru_pkg.sv
hdl/rru_ctrl.sv
hdl/rru_dp.sv
hdl/register_rename_unit.sv
tb/rru_checker.sv
tb/tb_register_rename_unit.sv
